// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, sizes and helpers of the sequence list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int FIDX_W = 4;
    localparam int ELEM_W = 32;
    localparam int LEN_W  = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_FIND       = 3'd4,
        OP_INSERT     = 3'd5,
        OP_ERASE      = 3'd6,
        OP_PRINT      = 3'd7
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         kind;
        logic [CNT_W-1:0] at;
        logic [CNT_W-1:0] count;
        t_word            word;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_PRINT
    } t_state;

    function automatic logic [ELEM_W-1:0] widen_word(input t_word w);
        logic signed [WORD_WIDTH-1:0] s;
        s = $signed(w);
        return ELEM_W'(s);
    endfunction

endpackage

// ===== hdl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds a word, shifts towards either neighbour, compares.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_cmd        i_cmd,
    input  t_word            i_left,
    input  t_word            i_right,
    output t_word            o_data,
    output logic             o_match
);

    t_word            r_data;
    t_word            n_data;
    logic [CNT_W-1:0] w_idx;
    logic [CNT_W-1:0] w_idx_p1;

    assign w_idx    = CNT_W'(i_idx);
    assign w_idx_p1 = w_idx + CNT_W'(1);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.kind)
            CMD_OPEN: begin
                if (w_idx == i_cmd.at) begin
                    n_data = i_cmd.word;
                end else if (w_idx > i_cmd.at && w_idx <= i_cmd.count) begin
                    n_data = i_left;
                end
            end
            CMD_CLOSE: begin
                if (w_idx >= i_cmd.at && w_idx_p1 < i_cmd.count) begin
                    n_data = i_right;
                end
            end
            CMD_ROTATE: begin
                if (w_idx_p1 < i_cmd.count) begin
                    n_data = i_right;
                end else if (w_idx_p1 == i_cmd.count) begin
                    n_data = i_cmd.word;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_cmd.word) && (w_idx < i_cmd.count);

endmodule

// ===== hdl/sequence_list_engine.sv =====
// ----------------------------------------------------------------------------
// sequence_list_engine
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on i_in_valid / o_in_ready with opcode, value and position;
// results leave on o_out_valid / i_out_ready with status, found index,
// element, length and last.
// Every request except print gives one result, registered in the cycle after
// the request is taken; a new request is taken in every cycle in which the
// result register is free or being emptied, so one request per cycle.
// Insert and erase shift all later cells at once; find compares every cell
// in parallel and picks the lowest match.
// Print rotates the list through cell zero, one element per cycle while the
// receiver takes them: the engine first enters its print state, then registers
// each element from cell zero, count results in all, and the list ends where
// it started. No request is taken while a print drains.
// Reset empties the list; stored words are left as they were.
// A stalled receiver holds the result register and the block takes nothing
// new until it is emptied.
// ----------------------------------------------------------------------------
module sequence_list_engine
    import sle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [FIDX_W-1:0] o_found_index,
    output logic [ELEM_W-1:0] o_element,
    output logic [LEN_W-1:0]  o_length,
    output logic              o_last
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_pidx, n_pidx;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [FIDX_W-1:0]   r_found, n_found;
    logic [ELEM_W-1:0]   r_element, n_element;
    logic                r_last, n_last;

    t_cell_cmd           w_cmd;
    t_word               w_word;
    t_word               w_data [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [IDX_W-1:0]    w_first;
    logic                w_slot_free;
    logic                w_accept;
    logic                w_full;
    logic                w_print_last;

    assign w_word = WORD_WIDTH'($unsigned(i_value));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            sle_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (IDX_W'(g)),
                .i_cmd   (w_cmd),
                .i_left  ((g == 0) ? w_cmd.word : w_data[(g == 0) ? 0 : g - 1]),
                .i_right ((g == CAPACITY - 1) ? w_cmd.word
                                              : w_data[(g == CAPACITY - 1) ? g : g + 1]),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    // lowest matching cell wins
    always_comb begin
        w_first = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_first = IDX_W'(k);
            end
        end
    end

    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && w_slot_free;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign w_print_last = ((r_pidx + CNT_W'(1)) == r_count);

    // command to the cell row
    always_comb begin
        w_cmd.kind  = CMD_HOLD;
        w_cmd.at    = '0;
        w_cmd.count = r_count;
        w_cmd.word  = w_word;
        if (r_state == S_PRINT) begin
            if (w_slot_free) begin
                // head goes out and wraps round to the tail
                w_cmd.kind = CMD_ROTATE;
                w_cmd.word = w_data[0];
            end
        end else if (w_accept) begin
            unique case (t_opcode'(i_opcode))
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (!w_full) begin
                        w_cmd.kind = CMD_OPEN;
                        w_cmd.at   = (t_opcode'(i_opcode) == OP_PUSH_BACK)
                                     ? r_count : '0;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count != '0) begin
                        w_cmd.kind = CMD_CLOSE;
                    end
                end
                OP_INSERT: begin
                    if (CMP_W'(i_position) <= CMP_W'(r_count) && !w_full) begin
                        w_cmd.kind = CMD_OPEN;
                        w_cmd.at   = CNT_W'(i_position);
                    end
                end
                OP_ERASE: begin
                    if (r_count != '0 && CMP_W'(i_position) < CMP_W'(r_count)) begin
                        w_cmd.kind = CMD_CLOSE;
                        w_cmd.at   = CNT_W'(i_position);
                    end
                end
                default: begin
                    w_cmd.kind = CMD_HOLD;
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pidx      = r_pidx;
        n_out_valid = w_slot_free ? 1'b0 : r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_element   = r_element;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_found     = '0;
                    n_element   = '0;
                    n_last      = 1'b1;
                    unique case (t_opcode'(i_opcode))
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_FIND: begin
                            if (|w_match) begin
                                n_found = FIDX_W'(w_first);
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        OP_INSERT: begin
                            if (CMP_W'(i_position) > CMP_W'(r_count)) begin
                                n_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (CMP_W'(i_position) >= CMP_W'(r_count)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        OP_PRINT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_PRINT;
                                n_pidx      = '0;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_PRINT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_found     = '0;
                    n_element   = widen_word(w_data[0]);
                    n_last      = w_print_last;
                    n_pidx      = r_pidx + CNT_W'(1);
                    if (w_print_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pidx      <= n_pidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_found   <= n_found;
        r_element <= n_element;
        r_last    <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_element     = r_element;
    assign o_length      = LEN_W'(r_count);
    assign o_last        = r_last;

endmodule

// ===== hdl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the sequence list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker
    import sle_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [OP_W-1:0]   i_opcode,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [LEN_W-1:0]  o_length,
    input logic              o_last
);

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_last))
        else $error("result changed while stalled");

    // every request other than print answers in the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode != OP_PRINT) |=> o_out_valid && o_last)
        else $error("single result missing");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_length == LEN_W'(CAPACITY))
        else $error("full reported below capacity");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_length == '0) && o_last)
        else $error("empty reported with entries");

endmodule

bind sequence_list_engine sle_checker u_sle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_opcode    (i_opcode),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_length    (o_length),
    .o_last      (o_last)
);
